### hdl/blc_pkg.sv
package blc_pkg;

    // field widths
    localparam int ACTION_W = 3;
    localparam int LEVEL_W  = 7;
    localparam int REQ_W    = 8;
    localparam int MREQ_W   = 2;
    localparam int HOUR_W   = 5;
    localparam int TIME_W   = 32;
    localparam int DUTY_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // event codes
    localparam logic [ACTION_W-1:0] ACT_SET          = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INC          = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DEC          = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE_LIGHT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SET_MODE     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE_MODE  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_TICK         = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_LEVEL        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MORNING_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_LEVEL          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENING_LEVEL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LATE_EVENING_LEVEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_PERIOD        = 3'd7;

    // modes
    localparam logic                MODE_MANUAL   = 1'b0;
    localparam logic                MODE_AUTO     = 1'b1;
    localparam logic [MREQ_W-1:0]   MODE_REQ_AUTO = 2'd1;

    // levels
    localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL   = 7'd50;
    localparam logic [LEVEL_W-1:0] LEVEL_CEIL      = 7'd100;
    localparam logic [LEVEL_W-1:0] ONOFF_THRESHOLD = 7'd50;
    localparam logic [LEVEL_W-1:0] STEP_20  = 7'd20;
    localparam logic [LEVEL_W-1:0] STEP_40  = 7'd40;
    localparam logic [LEVEL_W-1:0] STEP_60  = 7'd60;
    localparam logic [LEVEL_W-1:0] STEP_80  = 7'd80;
    localparam logic [LEVEL_W-1:0] STEP_100 = 7'd100;

    // hour boundaries of the auto schedule
    localparam logic [HOUR_W-1:0] HOUR_MORNING      = 5'd6;
    localparam logic [HOUR_W-1:0] HOUR_DAY          = 5'd8;
    localparam logic [HOUR_W-1:0] HOUR_EVENING      = 5'd18;
    localparam logic [HOUR_W-1:0] HOUR_LATE_EVENING = 5'd20;
    localparam logic [HOUR_W-1:0] HOUR_NIGHT        = 5'd22;

    // register reset values
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL          = 7'd0;
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL          = 7'd100;
    localparam logic [LEVEL_W-1:0] RST_NIGHT_LEVEL        = 7'd10;
    localparam logic [LEVEL_W-1:0] RST_MORNING_LEVEL      = 7'd50;
    localparam logic [LEVEL_W-1:0] RST_DAY_LEVEL          = 7'd100;
    localparam logic [LEVEL_W-1:0] RST_EVENING_LEVEL      = 7'd70;
    localparam logic [LEVEL_W-1:0] RST_LATE_EVENING_LEVEL = 7'd30;
    localparam logic [TIME_W-1:0]  RST_AUTO_PERIOD        = 32'd300000;

    // duty = level * 1023 / 100, as one multiply by 1023 * ceil(2^24 / 100)
    localparam int                DUTY_SHIFT = 24;
    localparam int                DUTY_PROD_W = 35;
    localparam logic [27:0]       DUTY_MUL   = 28'd171631779;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [REQ_W-1:0]    level_request;
        logic [MREQ_W-1:0]   mode_request;
        logic [HOUR_W-1:0]   hour_of_day;
        logic                time_valid;
        logic [TIME_W-1:0]   now_ms;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_percent;
        logic [DUTY_W-1:0]  pwm_duty;
        logic               onoff_level;
        logic               mode_now;
        logic               light_on;
        logic               level_written;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] night_level;
        logic [LEVEL_W-1:0] morning_level;
        logic [LEVEL_W-1:0] day_level;
        logic [LEVEL_W-1:0] evening_level;
        logic [LEVEL_W-1:0] late_evening_level;
        logic [TIME_W-1:0]  auto_period_ms;
    } t_cfg;

    // pwm duty for a level of at most 100
    function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] lvl);
        logic [DUTY_PROD_W-1:0] prod;
        prod = DUTY_PROD_W'(lvl) * DUTY_PROD_W'(DUTY_MUL);
        return prod[DUTY_SHIFT +: DUTY_W];
    endfunction

endpackage

### hdl/blc_in_if.sv
interface blc_in_if;
    import blc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/blc_out_if.sv
interface blc_out_if;
    import blc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/blc_cfg.sv
module blc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [blc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [blc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output blc_pkg::t_cfg                    o_cfg
);
    import blc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_LEVEL:          n_cfg.min_level          = i_cfg_data[LEVEL_W-1:0];
                CFG_MAX_LEVEL:          n_cfg.max_level          = i_cfg_data[LEVEL_W-1:0];
                CFG_NIGHT_LEVEL:        n_cfg.night_level        = i_cfg_data[LEVEL_W-1:0];
                CFG_MORNING_LEVEL:      n_cfg.morning_level      = i_cfg_data[LEVEL_W-1:0];
                CFG_DAY_LEVEL:          n_cfg.day_level          = i_cfg_data[LEVEL_W-1:0];
                CFG_EVENING_LEVEL:      n_cfg.evening_level      = i_cfg_data[LEVEL_W-1:0];
                CFG_LATE_EVENING_LEVEL: n_cfg.late_evening_level = i_cfg_data[LEVEL_W-1:0];
                CFG_AUTO_PERIOD:        n_cfg.auto_period_ms     = i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_level          <= RST_MIN_LEVEL;
            r_cfg.max_level          <= RST_MAX_LEVEL;
            r_cfg.night_level        <= RST_NIGHT_LEVEL;
            r_cfg.morning_level      <= RST_MORNING_LEVEL;
            r_cfg.day_level          <= RST_DAY_LEVEL;
            r_cfg.evening_level      <= RST_EVENING_LEVEL;
            r_cfg.late_evening_level <= RST_LATE_EVENING_LEVEL;
            r_cfg.auto_period_ms     <= RST_AUTO_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/blc_step.sv
module blc_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  blc_pkg::t_in_item i_item,
    input  blc_pkg::t_cfg     i_cfg,
    output blc_pkg::t_out_item o_result
);
    import blc_pkg::*;

    logic [LEVEL_W-1:0] r_level,  n_level;
    logic               r_mode,   n_mode;
    logic [LEVEL_W-1:0] r_manual_level, n_manual_level;
    logic [TIME_W-1:0]  r_last_update_ms, n_last_update_ms;
    logic               r_on_flag, n_on_flag;

    logic [LEVEL_W-1:0] hour_level;
    logic [LEVEL_W-1:0] step_up;
    logic [LEVEL_W-1:0] step_down;
    logic               eval_write;
    logic [REQ_W-1:0]   eval_val;
    logic [TIME_W-1:0]  elapsed;
    logic               do_write;
    logic               keep_manual;
    logic [REQ_W-1:0]   write_val;
    logic [REQ_W-1:0]   clamped;

    // scheduled level for the hour, out-of-range hours count as night
    always_comb begin
        if (i_item.hour_of_day >= HOUR_NIGHT || i_item.hour_of_day < HOUR_MORNING) begin
            hour_level = i_cfg.night_level;
        end else if (i_item.hour_of_day < HOUR_DAY) begin
            hour_level = i_cfg.morning_level;
        end else if (i_item.hour_of_day < HOUR_EVENING) begin
            hour_level = i_cfg.day_level;
        end else if (i_item.hour_of_day < HOUR_LATE_EVENING) begin
            hour_level = i_cfg.evening_level;
        end else begin
            hour_level = i_cfg.late_evening_level;
        end
    end

    // ladder steps
    always_comb begin
        if (r_level < STEP_20) begin
            step_up = STEP_20;
        end else if (r_level < STEP_40) begin
            step_up = STEP_40;
        end else if (r_level < STEP_60) begin
            step_up = STEP_60;
        end else if (r_level < STEP_80) begin
            step_up = STEP_80;
        end else begin
            step_up = STEP_100;
        end

        if (r_level > STEP_80) begin
            step_down = STEP_80;
        end else if (r_level > STEP_60) begin
            step_down = STEP_60;
        end else if (r_level > STEP_40) begin
            step_down = STEP_40;
        end else if (r_level > STEP_20) begin
            step_down = STEP_20;
        end else begin
            step_down = '0;
        end
    end

    // time evaluation: manual level without valid time, else hour level when it differs
    assign eval_write = !i_item.time_valid || (hour_level != r_level);
    assign eval_val   = i_item.time_valid ? REQ_W'(hour_level) : REQ_W'(r_manual_level);
    assign elapsed    = i_item.now_ms - r_last_update_ms;

    // event decode
    always_comb begin
        n_mode           = r_mode;
        n_on_flag        = r_on_flag;
        n_last_update_ms = r_last_update_ms;
        do_write         = 1'b0;
        keep_manual      = 1'b0;
        write_val        = REQ_W'(r_manual_level);
        unique case (i_item.action) inside
            ACT_SET: begin
                do_write  = 1'b1;
                write_val = i_item.level_request;
            end
            ACT_INC: begin
                do_write  = (r_mode == MODE_MANUAL);
                write_val = REQ_W'(step_up);
            end
            ACT_DEC: begin
                do_write  = (r_mode == MODE_MANUAL);
                write_val = REQ_W'(step_down);
            end
            ACT_TOGGLE_LIGHT: begin
                n_on_flag = !r_on_flag;
                if (r_on_flag) begin
                    do_write    = 1'b1;
                    write_val   = '0;
                    keep_manual = 1'b1;
                end else if (r_mode == MODE_AUTO) begin
                    do_write  = eval_write;
                    write_val = eval_val;
                end else begin
                    do_write  = 1'b1;
                end
            end
            ACT_SET_MODE, ACT_TOGGLE_MODE: begin
                if (i_item.action == ACT_SET_MODE) begin
                    n_mode = (i_item.mode_request == MODE_REQ_AUTO);
                end else begin
                    n_mode = !r_mode;
                end
                n_last_update_ms = i_item.now_ms;
                if (n_mode == MODE_AUTO) begin
                    do_write  = eval_write;
                    write_val = eval_val;
                end else begin
                    do_write  = 1'b1;
                end
            end
            ACT_TICK: begin
                if (elapsed > i_cfg.auto_period_ms) begin
                    n_last_update_ms = i_item.now_ms;
                    if (r_mode == MODE_AUTO) begin
                        do_write  = eval_write;
                        write_val = eval_val;
                    end
                end
            end
            default: ;
        endcase
    end

    // clamp to min, then max, then 100
    always_comb begin
        clamped = write_val;
        if (clamped < REQ_W'(i_cfg.min_level)) begin
            clamped = REQ_W'(i_cfg.min_level);
        end
        if (clamped > REQ_W'(i_cfg.max_level)) begin
            clamped = REQ_W'(i_cfg.max_level);
        end
        if (clamped > REQ_W'(LEVEL_CEIL)) begin
            clamped = REQ_W'(LEVEL_CEIL);
        end
    end

    // next level and remembered manual level
    assign n_level        = do_write ? clamped[LEVEL_W-1:0] : r_level;
    assign n_manual_level = (do_write && n_mode == MODE_MANUAL && !keep_manual)
                          ? clamped[LEVEL_W-1:0] : r_manual_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level          <= DEFAULT_LEVEL;
            r_mode           <= MODE_MANUAL;
            r_manual_level   <= DEFAULT_LEVEL;
            r_last_update_ms <= '0;
            r_on_flag        <= 1'b1;
        end else if (i_fire) begin
            r_level          <= n_level;
            r_mode           <= n_mode;
            r_manual_level   <= n_manual_level;
            r_last_update_ms <= n_last_update_ms;
            r_on_flag        <= n_on_flag;
        end
    end

    // result fields
    always_comb begin
        o_result.level_percent = n_level;
        o_result.pwm_duty      = duty_of(n_level);
        o_result.onoff_level   = (n_level > ONOFF_THRESHOLD);
        o_result.mode_now      = n_mode;
        o_result.light_on      = n_on_flag;
        o_result.level_written = do_write;
    end

endmodule

### hdl/backlight_level_controller.sv
// Backlight level controller
//
// i_in carries one event request per transfer (valid/ready): set level, step up
// or down, toggle the light, set or toggle the mode, or a time tick. o_out
// returns exactly one result request per event: level, pwm duty, on-off drive,
// mode, light flag and whether a level was written.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data, one per cycle;
// the user must write only while no event is in flight, unchecked by the block.
//
// An event taken into the input register is decided by the step logic and its
// result is captured in the result register, from which o_out offers it.
// Throughput: one event per cycle while o_out is not stalled, set by the single
// decision stage between the input register and the result register.
// Reset (synchronous, active low) clears both register stages, restores the
// register defaults, level and manual level 50, manual mode and light on.
// When o_out is stalled the result holds, one more event is still taken into
// the input register, and then i_in.ready drops until the result is taken.
module backlight_level_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    blc_in_if.sink                         i_in,
    blc_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [blc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [blc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import blc_pkg::*;

    t_cfg      cfg;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      advance;
    logic      fire;
    logic      in_ready;

    // handshake control
    assign advance  = !r_out_valid || o_out.ready;
    assign fire     = r_in_valid && advance;
    assign in_ready = !r_in_valid || advance;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    blc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    blc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in_item <= i_in.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

endmodule

### hdl/blc_checker.sv
module blc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  blc_pkg::t_out_item i_out_data
);
    import blc_pkg::*;

    // no result straight after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // level stays within 0..100 and the on-off drive follows it
    a_level_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.level_percent <= LEVEL_CEIL)
            && (i_out_data.onoff_level == (i_out_data.level_percent > ONOFF_THRESHOLD)))
        else $error("level out of range or on-off drive mismatch");

    // duty matches the level
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.pwm_duty == duty_of(i_out_data.level_percent))
        else $error("pwm duty does not match level");

endmodule

bind backlight_level_controller blc_checker u_blc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

### bench/backlight_level_controller_tb.sv
`timescale 1ns / 100ps

module backlight_level_controller_tb;
    import blc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_EVENTS = 135;
    localparam int MAX_WAIT     = 16;
    localparam int REPORT_LIMIT = 10;
    localparam int PWM_FULL     = 1023;
    localparam int PERCENT      = 100;

    // unused event code, must leave everything alone
    localparam logic [ACTION_W-1:0] ACT_VOID = 3'd7;

    localparam bit KNOWN = 1'b1;
    localparam bit PRED  = 1'b0;

    typedef struct packed {
        t_in_item  ev;
        bit        typed;
        t_out_item want;
    } t_row;

    localparam t_out_item FROM_MODEL = '0;
    localparam int        ROWS       = 27;

    // directed requests, default settings
    localparam t_row SCRIPT [ROWS] = '{
        '{'{ACT_TICK, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, KNOWN,
          '{7'd50, 10'd511, 1'b0, MODE_MANUAL, 1'b1, 1'b0}},
        '{'{ACT_SET, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, KNOWN,
          '{7'd0, 10'd0, 1'b0, MODE_MANUAL, 1'b1, 1'b1}},
        '{'{ACT_SET, 8'd255, 2'd0, 5'd0, 1'b1, 32'd0}, KNOWN,
          '{7'd100, 10'd1023, 1'b1, MODE_MANUAL, 1'b1, 1'b1}},
        '{'{ACT_SET, 8'd51, 2'd0, 5'd0, 1'b1, 32'd0}, KNOWN,
          '{7'd51, 10'd521, 1'b1, MODE_MANUAL, 1'b1, 1'b1}},
        '{'{ACT_SET, 8'd50, 2'd0, 5'd0, 1'b1, 32'd0}, KNOWN,
          '{7'd50, 10'd511, 1'b0, MODE_MANUAL, 1'b1, 1'b1}},
        '{'{ACT_INC, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_INC, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_INC, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_DEC, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_SET, 8'd21, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_DEC, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_TOGGLE_LIGHT, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_TOGGLE_LIGHT, 8'd0, 2'd0, 5'd0, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_VOID, 8'd99, 2'd1, 5'd12, 1'b1, 32'd5}, KNOWN,
          '{7'd20, 10'd204, 1'b0, MODE_MANUAL, 1'b1, 1'b0}},
        '{'{ACT_SET_MODE, 8'd0, MODE_REQ_AUTO, 5'd12, 1'b1, 32'd1000}, PRED, FROM_MODEL},
        '{'{ACT_INC, 8'd0, 2'd0, 5'd12, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_DEC, 8'd0, 2'd0, 5'd12, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_TICK, 8'd0, 2'd0, 5'd23, 1'b1, 32'd301000}, PRED, FROM_MODEL},
        '{'{ACT_TICK, 8'd0, 2'd0, 5'd23, 1'b1, 32'd301001}, PRED, FROM_MODEL},
        '{'{ACT_TOGGLE_LIGHT, 8'd0, 2'd0, 5'd7, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_TOGGLE_LIGHT, 8'd0, 2'd0, 5'd7, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_SET, 8'd90, 2'd0, 5'd7, 1'b1, 32'd0}, PRED, FROM_MODEL},
        '{'{ACT_SET_MODE, 8'd0, 2'd2, 5'd0, 1'b1, 32'd2000}, PRED, FROM_MODEL},
        '{'{ACT_TOGGLE_MODE, 8'd0, 2'd0, 5'd31, 1'b1, 32'hFFFF_FFF0}, PRED, FROM_MODEL},
        '{'{ACT_TICK, 8'd0, 2'd0, 5'd3, 1'b1, 32'h0004_93F0}, PRED, FROM_MODEL},
        '{'{ACT_TICK, 8'd0, 2'd0, 5'd20, 1'b1, 32'h0009_3000}, PRED, FROM_MODEL},
        '{'{ACT_SET_MODE, 8'd0, MODE_REQ_AUTO, 5'd12, 1'b0, 32'd7}, PRED, FROM_MODEL}
    };

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    blc_in_if  ev_ch ();
    blc_out_if res_ch ();

    // shadow of the settings and of the controller state
    t_cfg               sett;
    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W-1:0] lv_manual;
    logic               lv_mode;
    logic               lv_on;
    logic               lv_wrote;
    logic [TIME_W-1:0]  lv_stamp;

    t_out_item   reports_due [$];
    int unsigned faults = 0;
    int unsigned shown  = 0;
    bit          calm   = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    backlight_level_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (ev_ch),
        .o_out      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clamp and store a level, manual mode also remembers it
    function automatic void settle_level(int unsigned v);
        if (v < 32'(sett.min_level)) v = 32'(sett.min_level);
        if (v > 32'(sett.max_level)) v = 32'(sett.max_level);
        if (v > 32'(LEVEL_CEIL)) v = 32'(LEVEL_CEIL);
        lv = LEVEL_W'(v);
        if (lv_mode == MODE_MANUAL) lv_manual = LEVEL_W'(v);
        lv_wrote = 1'b1;
    endfunction

    // time of day lookup, hours past 23 count as night
    function automatic void follow_schedule(logic [HOUR_W-1:0] hr, logic ok);
        logic [LEVEL_W-1:0] target;
        if (!ok) begin
            settle_level(32'(lv_manual));
        end else begin
            if (hr >= HOUR_NIGHT || hr < HOUR_MORNING) target = sett.night_level;
            else if (hr < HOUR_DAY) target = sett.morning_level;
            else if (hr < HOUR_EVENING) target = sett.day_level;
            else if (hr < HOUR_LATE_EVENING) target = sett.evening_level;
            else target = sett.late_evening_level;
            // compared before clamping
            if (target != lv) settle_level(32'(target));
        end
    endfunction

    function automatic void enter_mode(logic m, t_in_item ev);
        lv_mode = m;
        if (m == MODE_AUTO) follow_schedule(ev.hour_of_day, ev.time_valid);
        else settle_level(32'(lv_manual));
        lv_stamp = ev.now_ms;
    endfunction

    // one event request in, the report it should produce out
    function automatic t_out_item step_backlight(t_in_item ev);
        t_out_item          r;
        logic [LEVEL_W-1:0] keep;
        logic [TIME_W-1:0]  elapsed;
        lv_wrote = 1'b0;
        case (ev.action)
            ACT_SET: begin
                settle_level(32'(ev.level_request));
            end
            ACT_INC: begin
                if (lv_mode == MODE_MANUAL) begin
                    if (lv < STEP_20) settle_level(32'(STEP_20));
                    else if (lv < STEP_40) settle_level(32'(STEP_40));
                    else if (lv < STEP_60) settle_level(32'(STEP_60));
                    else if (lv < STEP_80) settle_level(32'(STEP_80));
                    else settle_level(32'(STEP_100));
                end
            end
            ACT_DEC: begin
                if (lv_mode == MODE_MANUAL) begin
                    if (lv > STEP_80) settle_level(32'(STEP_80));
                    else if (lv > STEP_60) settle_level(32'(STEP_60));
                    else if (lv > STEP_40) settle_level(32'(STEP_40));
                    else if (lv > STEP_20) settle_level(32'(STEP_20));
                    else settle_level(0);
                end
            end
            ACT_TOGGLE_LIGHT: begin
                // switching off must not disturb the remembered manual level
                if (lv_on) begin
                    keep = lv_manual;
                    settle_level(0);
                    lv_manual = keep;
                end else if (lv_mode == MODE_AUTO) begin
                    follow_schedule(ev.hour_of_day, ev.time_valid);
                end else begin
                    settle_level(32'(lv_manual));
                end
                lv_on = ~lv_on;
            end
            ACT_SET_MODE: begin
                enter_mode((ev.mode_request == MODE_REQ_AUTO) ? MODE_AUTO : MODE_MANUAL, ev);
            end
            ACT_TOGGLE_MODE: begin
                enter_mode((lv_mode == MODE_MANUAL) ? MODE_AUTO : MODE_MANUAL, ev);
            end
            ACT_TICK: begin
                // elapsed time wraps with the millisecond counter
                elapsed = ev.now_ms - lv_stamp;
                if (elapsed > sett.auto_period_ms) begin
                    if (lv_mode == MODE_AUTO) follow_schedule(ev.hour_of_day, ev.time_valid);
                    lv_stamp = ev.now_ms;
                end
            end
            default: begin
            end
        endcase
        r.level_percent = lv;
        r.pwm_duty      = DUTY_W'((int'(lv) * PWM_FULL) / PERCENT);
        r.onoff_level   = (lv > ONOFF_THRESHOLD);
        r.mode_now      = lv_mode;
        r.light_on      = lv_on;
        r.level_written = lv_wrote;
        return r;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // level setting biased towards the edges and past 100
    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return LEVEL_CEIL;
            2: return LEVEL_W'($urandom_range(101, 127));
            default: return LEVEL_W'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (shown < REPORT_LIMIT) begin
                $display("%0t: %s expected %0d, got %0d", $realtime, field, want, got);
            end
            shown++;
            faults++;
        end
    endfunction

    // send one event request, predicting its report when it is taken
    task automatic send_event(t_row row);
        int        gap;
        t_out_item want;
        gap = draw_wait();
        if (gap > 0) begin
            ev_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ev_ch.valid = 1'b1;
        ev_ch.data  = row.ev;
        do @(posedge i_clk); while (ev_ch.ready !== 1'b1);
        want = step_backlight(row.ev);
        reports_due.push_back(row.typed ? row.want : want);
        @(negedge i_clk);
    endtask

    // hold off the sender until every report is back
    task automatic wait_drained();
        ev_ch.valid = 1'b0;
        while (reports_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // report side with random stalls
    initial begin : report_sink
        t_out_item want;
        t_out_item got;
        int        stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            got = res_ch.data;
            if (reports_due.size() == 0) begin
                if (shown < REPORT_LIMIT) begin
                    $display("%0t: report with no event pending", $realtime);
                end
                shown++;
                faults++;
            end else begin
                want = reports_due.pop_front();
                compare_field("level_percent", 32'(want.level_percent),
                              32'(got.level_percent));
                compare_field("pwm_duty", 32'(want.pwm_duty), 32'(got.pwm_duty));
                compare_field("onoff_level", 32'(want.onoff_level), 32'(got.onoff_level));
                compare_field("mode_now", 32'(want.mode_now), 32'(got.mode_now));
                compare_field("light_on", 32'(want.light_on), 32'(got.light_on));
                compare_field("level_written", 32'(want.level_written),
                              32'(got.level_written));
            end
            @(negedge i_clk);
        end
    end

    // give up after a long stretch with no request moving
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((ev_ch.valid === 1'b1 && ev_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("backlight_level_controller test failed");
        $finish;
    end

    initial begin : stimulus
        t_row                  row;
        t_cfg                  next_sett;
        logic [CFG_DATA_W-1:0] word;
        int                    pick;
        int                    phase;
        int                    n;
        int                    k;

        ev_ch.valid = 1'b0;
        ev_ch.data  = '0;

        // state after reset
        sett = '{RST_MIN_LEVEL, RST_MAX_LEVEL, RST_NIGHT_LEVEL, RST_MORNING_LEVEL,
                 RST_DAY_LEVEL, RST_EVENING_LEVEL, RST_LATE_EVENING_LEVEL, RST_AUTO_PERIOD};
        lv        = DEFAULT_LEVEL;
        lv_manual = DEFAULT_LEVEL;
        lv_mode   = MODE_MANUAL;
        lv_on     = 1'b1;
        lv_wrote  = 1'b0;
        lv_stamp  = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < ROWS; k++) send_event(SCRIPT[k]);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                // settings only change once every report is back
                wait_drained();
                next_sett.min_level = ($urandom_range(0, 3) == 0) ?
                                      pick_level() : LEVEL_W'($urandom_range(0, 40));
                next_sett.max_level = ($urandom_range(0, 3) == 0) ?
                                      pick_level() : LEVEL_W'($urandom_range(60, 100));
                next_sett.night_level        = pick_level();
                next_sett.morning_level      = pick_level();
                next_sett.day_level          = pick_level();
                next_sett.evening_level      = pick_level();
                next_sett.late_evening_level = pick_level();
                case ($urandom_range(0, 4))
                    0: next_sett.auto_period_ms = '0;
                    1: next_sett.auto_period_ms = 32'd1;
                    2: next_sett.auto_period_ms = '1;
                    3: next_sett.auto_period_ms = $urandom;
                    default: next_sett.auto_period_ms = $urandom_range(1, 400000);
                endcase
                // a few fixed corners
                case (phase)
                    1: begin
                        next_sett = '0;
                        next_sett.max_level = LEVEL_CEIL;
                    end
                    2: begin
                        next_sett.min_level      = LEVEL_CEIL;
                        next_sett.max_level      = '0;
                        next_sett.auto_period_ms = '1;
                    end
                    3: begin
                        next_sett.max_level          = '1;
                        next_sett.night_level        = '1;
                        next_sett.day_level          = '1;
                        next_sett.late_evening_level = '1;
                        next_sett.auto_period_ms     = 32'd1;
                    end
                    default: begin
                    end
                endcase
                sett = next_sett;

                // write every register, level ones with junk in the upper bits
                i_cfg_we = 1'b1;
                for (k = 0; k <= int'(CFG_AUTO_PERIOD); k++) begin
                    i_cfg_idx = CFG_IDX_W'(k);
                    word      = $urandom;
                    case (CFG_IDX_W'(k))
                        CFG_MIN_LEVEL:          word[LEVEL_W-1:0] = next_sett.min_level;
                        CFG_MAX_LEVEL:          word[LEVEL_W-1:0] = next_sett.max_level;
                        CFG_NIGHT_LEVEL:        word[LEVEL_W-1:0] = next_sett.night_level;
                        CFG_MORNING_LEVEL:      word[LEVEL_W-1:0] = next_sett.morning_level;
                        CFG_DAY_LEVEL:          word[LEVEL_W-1:0] = next_sett.day_level;
                        CFG_EVENING_LEVEL:      word[LEVEL_W-1:0] = next_sett.evening_level;
                        CFG_LATE_EVENING_LEVEL: word[LEVEL_W-1:0] =
                                                next_sett.late_evening_level;
                        default:                word = next_sett.auto_period_ms;
                    endcase
                    i_cfg_data = word;
                    @(negedge i_clk);
                end
                i_cfg_we = 1'b0;
            end

            // every third phase runs without idling on either side
            calm = (phase % 3 == 2);

            for (n = 0; n < PHASE_EVENTS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 18) row.ev.action = ACT_SET;
                else if (pick < 30) row.ev.action = ACT_INC;
                else if (pick < 42) row.ev.action = ACT_DEC;
                else if (pick < 52) row.ev.action = ACT_TOGGLE_LIGHT;
                else if (pick < 62) row.ev.action = ACT_SET_MODE;
                else if (pick < 74) row.ev.action = ACT_TOGGLE_MODE;
                else if (pick < 97) row.ev.action = ACT_TICK;
                else row.ev.action = ACT_VOID;
                row.ev.level_request = ($urandom_range(0, 3) == 0) ?
                                       REQ_W'($urandom_range(0, 255)) :
                                       REQ_W'($urandom_range(0, 110));
                row.ev.mode_request  = MREQ_W'($urandom_range(0, 3));
                row.ev.hour_of_day   = ($urandom_range(0, 7) == 0) ?
                                       HOUR_W'($urandom_range(24, 31)) :
                                       HOUR_W'($urandom_range(0, 23));
                row.ev.time_valid    = ($urandom_range(0, 4) != 0);
                row.ev.now_ms        = $urandom;
                // ticks land around the re-evaluation threshold
                if (row.ev.action == ACT_TICK) begin
                    case ($urandom_range(0, 4))
                        0: row.ev.now_ms = lv_stamp + sett.auto_period_ms;
                        1: row.ev.now_ms = lv_stamp + sett.auto_period_ms + 32'd1;
                        2: row.ev.now_ms = lv_stamp + sett.auto_period_ms - 32'd1;
                        3: row.ev.now_ms = lv_stamp + TIME_W'($urandom_range(0, 1000));
                        default: row.ev.now_ms = $urandom;
                    endcase
                end
                row.typed = PRED;
                row.want  = FROM_MODEL;
                send_event(row);
            end
        end

        wait_drained();
        if (faults == 0 && reports_due.size() == 0) begin
            $display("backlight_level_controller test passed");
        end else begin
            $display("backlight_level_controller test failed");
        end
        $finish;
    end

endmodule
